// File: hw/rtl/id_length_prefixed_deframer_top_assert.svh
// assertion macros for the deframer
`ifndef ID_LENGTH_PREFIXED_DEFRAMER_TOP_ASSERT_SVH
`define ID_LENGTH_PREFIXED_DEFRAMER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// concurrent check, skipped while reset is high
`define IDLD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deframer assertion failed");
// concurrent check that also holds during reset
`define IDLD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("deframer assertion failed");
`else
`define IDLD_ASSERT(lbl, clk, rst, prop)
`define IDLD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/idld_pkg.sv
package idld_pkg;

   // header is a 16-bit id and a 16-bit length, both msb first
   localparam int unsigned HdrBytes = 4;
   localparam int unsigned HcntW    = 2;

   typedef logic [HcntW-1:0] hcount_type;

   typedef enum logic [1:0] {
      ST_HDR  = 2'b01,
      ST_BODY = 2'b10
   } state_type;

   typedef struct packed {
      logic [15:0] msg_id;
      logic [7:0]  body_byte;
      logic        last_byte;
      logic        empty_msg;
   } rsp_item_type;

endpackage

// File: hw/rtl/idld_ifs.sv
interface idld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface idld_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] msg_id;
   logic [7:0]  body_byte;
   logic        last_byte;
   logic        empty_msg;

   modport source (output valid, output msg_id, output body_byte, output last_byte,
                   output empty_msg, input ready);
   modport sink   (input valid, input msg_id, input body_byte, input last_byte,
                   input empty_msg, output ready);
endinterface

// File: hw/rtl/idld_core.sv
`include "id_length_prefixed_deframer_top_assert.svh"

module idld_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            rx_byte,
   output logic                  res_valid,
   output idld_pkg::rsp_item_type res_item
);
   import idld_pkg::*;

   state_type   state_ff, state_in;
   hcount_type  hcount_ff, hcount_in;
   logic [15:0] cur_id_ff, cur_id_in;
   logic [15:0] cur_len_ff, cur_len_in;
   logic [15:0] left_ff, left_in;

   logic        hdr_end;
   logic        body_last;
   logic [15:0] new_len;

   assign hdr_end   = (hcount_ff == hcount_type'(HdrBytes - 1));
   assign body_last = (left_ff <= 16'd1);
   assign new_len   = {cur_len_ff[7:0], rx_byte};

   always_comb begin
      state_in   = state_ff;
      hcount_in  = hcount_ff;
      cur_id_in  = cur_id_ff;
      cur_len_in = cur_len_ff;
      left_in    = left_ff;
      res_valid  = 1'b0;
      res_item   = '{msg_id: cur_id_ff, body_byte: rx_byte, last_byte: 1'b0,
                     empty_msg: 1'b0};
      if (take) begin
         unique case (state_ff)
            ST_BODY: begin
               res_valid          = 1'b1;
               res_item.last_byte = body_last;
               if (body_last) begin
                  left_in   = '0;
                  state_in  = ST_HDR;
                  hcount_in = '0;
               end else begin
                  left_in = left_ff - 16'd1;
               end
            end
            ST_HDR: begin
               // first half of the header is the id, second half the length
               if (!hcount_ff[HcntW-1]) begin
                  cur_id_in = {cur_id_ff[7:0], rx_byte};
               end else begin
                  cur_len_in = new_len;
               end
               hcount_in = hcount_ff + hcount_type'(1);
               if (hdr_end) begin
                  if (new_len == 16'd0) begin
                     res_valid = 1'b1;
                     res_item  = '{msg_id: cur_id_ff, body_byte: 8'd0, last_byte: 1'b1,
                                   empty_msg: 1'b1};
                  end else begin
                     left_in  = new_len;
                     state_in = ST_BODY;
                  end
               end
            end
            default: begin
               state_in = ST_HDR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HDR;
         hcount_ff  <= '0;
         cur_id_ff  <= '0;
         cur_len_ff <= '0;
         left_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         hcount_ff  <= hcount_in;
         cur_id_ff  <= cur_id_in;
         cur_len_ff <= cur_len_in;
         left_ff    <= left_in;
      end
   end

   // a body in progress always has bytes to come and a cleared header count
   `IDLD_ASSERT(a_body_has_bytes, clock, reset, (state_ff == ST_BODY) |-> (left_ff != 16'd0))
   `IDLD_ASSERT(a_body_hcount_zero, clock, reset, (state_ff == ST_BODY) |-> (hcount_ff == '0))
   // final body byte returns to header parsing
   `IDLD_ASSERT(a_last_to_hdr, clock, reset,
      (take && state_ff == ST_BODY && body_last) |=> (state_ff == ST_HDR))
   // results only from body bytes or the closing byte of an empty message
   `IDLD_ASSERT(a_res_source, clock, reset,
      res_valid |-> (take && (state_ff == ST_BODY || (hdr_end && res_item.empty_msg))))

endmodule

// File: hw/rtl/id_length_prefixed_deframer_top.sv
// output: registered, shown in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle, header and body bytes alike, while the result
//   register is empty or draining; set by the single parser state update and the
//   one-entry result register
// reset: synchronous, active high; clears parser state and the result valid flag, result payload is left unreset
module id_length_prefixed_deframer_top (
   input logic        clock,
   input logic        reset,
   idld_req_if.sink   req,
   idld_rsp_if.source rsp
);
   import idld_pkg::*;

   // handshake at the input side
   logic         take;
   logic         res_valid;
   rsp_item_type res_item;

   // result register, parts the two channels
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // a new byte is taken whenever the result register is empty or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;

   // header collection and body byte counting
   idld_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req.rx_byte),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      // drained slot empties, refilled in the same cycle if a result item comes
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register needs no reset
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.msg_id    = rsp_item_ff.msg_id;
   assign rsp.body_byte = rsp_item_ff.body_byte;
   assign rsp.last_byte = rsp_item_ff.last_byte;
   assign rsp.empty_msg = rsp_item_ff.empty_msg;

endmodule
